[rtl/cnfh_pkg.sv]
`timescale 1ns / 1ps

package cnfh_pkg;

  // Size of the SDO parameter byte store and the width of its byte address.
  localparam int PARAM_BYTES = 1024;
  localparam int ADDR_W      = (PARAM_BYTES > 1) ? $clog2(PARAM_BYTES) : 1;

  // Range check on an SDO offset is done at this width so that offset + 4
  // never wraps, whatever the store size.
  localparam int LIM_W = 18;

  // Function codes (id bits 10..7).
  localparam logic [3:0] FN_NMT       = 4'd0;
  localparam logic [3:0] FN_SYNC      = 4'd1;
  localparam logic [3:0] FN_TPDO1     = 4'd3;
  localparam logic [3:0] FN_RPDO1     = 4'd4;
  localparam logic [3:0] FN_TPDO2     = 4'd5;
  localparam logic [3:0] FN_RPDO2     = 4'd6;
  localparam logic [3:0] FN_TPDO3     = 4'd7;
  localparam logic [3:0] FN_RPDO3     = 4'd8;
  localparam logic [3:0] FN_RPDO4     = 4'd10;
  localparam logic [3:0] FN_TSDO      = 4'd11;
  localparam logic [3:0] FN_RSDO      = 4'd12;
  localparam logic [3:0] FN_HEARTBEAT = 4'd14;

  // Operating modes.
  localparam logic [3:0] MODE_OFF     = 4'd0;
  localparam logic [3:0] MODE_STANDBY = 4'd1;
  localparam logic [3:0] MODE_CALIB   = 4'd2;
  localparam logic [3:0] MODE_RUN_LO  = 4'd3;
  localparam logic [3:0] MODE_RUN_HI  = 4'd10;
  localparam logic [3:0] MODE_SERVICE = 4'd11;

  // SDO command specifiers.
  localparam logic [2:0] CCS_WRITE = 3'd1;
  localparam logic [2:0] CCS_READ  = 3'd2;

  // Fault flag bits.
  localparam int FLT_RX_BIT   = 0;
  localparam int FLT_MODE_BIT = 1;

  // Target kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PV   = 2'd1;
  localparam logic [1:0] KIND_PT   = 2'd2;

  localparam logic [6:0] NODE_ID_RESET = 7'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } state_t;

endpackage

[rtl/can_node_frame_handler_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Beat contents
// --------  ---------  ----------------------  ----------------------------------------
// input     in         in_valid / in_stall     frame_id, frame_size, data_lo, data_hi,
//                                              position_now, velocity_now, torque_now
// result    out        out_valid / out_stall   reply_*, mode_now, fault_flags, pulses,
//                                              target_kind, target_first, target_second
// config    in         cfg_valid / cfg_ready   node_id
//
// One frame is handled at a time. An SDO write or read takes longer than a frame that does
// not touch the parameter store, because the byte-wide store has a single port and moves
// one byte per cycle. Reset is synchronous. After reset the store is swept to zero, one
// byte per cycle, over PARAM_BYTES (1024) bytes; no frame is accepted during the sweep,
// configuration is. The result sits in an output register, so a stalled result beat only
// holds the block when the next is ready.

module can_node_frame_handler_top
  import cnfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  node_id,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] frame_id,
  input  logic [3:0]  frame_size,
  input  logic [31:0] data_lo,
  input  logic [31:0] data_hi,
  input  logic [31:0] position_now,
  input  logic [31:0] velocity_now,
  input  logic [31:0] torque_now,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] reply_id,
  output logic [3:0]  reply_size,
  output logic [31:0] reply_lo,
  output logic [31:0] reply_hi,
  output logic [3:0]  mode_now,
  output logic [1:0]  fault_flags,
  output logic        drive_enable,
  output logic        loops_reset,
  output logic        watchdog_kick,
  output logic [1:0]  target_kind,
  output logic [31:0] target_first,
  output logic [31:0] target_second
);

  state_t state, state_next;

  // Architectural state held in flops.
  logic [6:0] node_addr;
  logic [3:0] mode;
  logic [1:0] fault;
  logic       drive;

  // Captured input beat.
  logic [10:0] fid;
  logic [3:0]  fsize;
  logic [31:0] dlo;
  logic [31:0] dhi;
  logic [31:0] pos;
  logic [31:0] vel;
  logic [31:0] trq;

  // Result under construction.
  logic [10:0] res_id;
  logic [3:0]  res_size;
  logic [31:0] res_lo;
  logic [31:0] res_hi;
  logic        res_loops;
  logic        res_kick;
  logic [1:0]  res_kind;
  logic [31:0] res_t1;
  logic [31:0] res_t2;

  // Store sequencing.
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] off;
  logic [1:0]        byte_cnt;
  logic              rd_vld;
  logic [1:0]        rd_idx;

  // Parameter store: single port, registered read.
  logic [7:0]        mem [PARAM_BYTES];
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  logic accept;
  logic load_out;

  // Decode of the captured frame.
  logic [6:0]  d_addr;
  logic [3:0]  d_func;
  logic [15:0] d_off;
  logic [2:0]  d_ccs;
  logic [7:0]  d_req;
  logic        d_hit;
  logic        d_off_bad;
  logic        req_is_run;
  logic        cur_is_run;
  logic [3:0]  mode_next;
  logic [1:0]  fault_next;
  logic        drive_next;
  logic [10:0] d_rid;
  logic [3:0]  d_rsize;
  logic [31:0] d_rlo;
  logic [31:0] d_rhi;
  logic        d_loops;
  logic        d_kick;
  logic [1:0]  d_kind;
  logic [31:0] d_t1;
  logic [31:0] d_t2;
  logic        d_sdo_wr;
  logic        d_sdo_rd;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Frame decode. Everything but the store access is settled in the DECODE state;
  // an NMT request runs through the mode transition rules here.
  always_comb begin
    d_addr     = fid[6:0];
    d_func     = fid[10:7];
    d_off      = dlo[23:8];
    d_ccs      = dlo[7:5];
    d_req      = dlo[7:0];
    d_hit      = (d_addr == 7'd0) || (d_addr == node_addr);
    d_off_bad  = ({2'b00, d_off} + LIM_W'(4)) > LIM_W'(PARAM_BYTES);
    req_is_run = (d_req >= {4'd0, MODE_RUN_LO}) && (d_req <= {4'd0, MODE_RUN_HI});
    cur_is_run = (mode >= MODE_RUN_LO) && (mode <= MODE_RUN_HI);

    mode_next  = mode;
    fault_next = fault;
    drive_next = drive;
    d_rid      = '0;
    d_rsize    = '0;
    d_rlo      = '0;
    d_rhi      = '0;
    d_loops    = 1'b0;
    d_kick     = 1'b0;
    d_kind     = KIND_NONE;
    d_t1       = '0;
    d_t2       = '0;
    d_sdo_wr   = 1'b0;
    d_sdo_rd   = 1'b0;

    if (d_hit) begin
      case (d_func)
        FN_NMT: begin
          if (fsize == 4'd0) begin
            fault_next[FLT_RX_BIT] = 1'b1;
          end else if (dlo[15:8] == {1'b0, node_addr} && d_req != {4'd0, mode}) begin
            drive_next = 1'b0;
            if (d_req == {4'd0, MODE_OFF} || d_req == {4'd0, MODE_STANDBY} ||
                d_req == {4'd0, MODE_SERVICE}) begin
              mode_next = d_req[3:0];
            end else if (d_req == {4'd0, MODE_CALIB}) begin
              mode_next  = d_req[3:0];
              d_loops    = 1'b1;
              drive_next = 1'b1;
            end else if (req_is_run && (mode == MODE_STANDBY || cur_is_run)) begin
              mode_next  = d_req[3:0];
              d_loops    = 1'b1;
              drive_next = 1'b1;
            end else begin
              // A run mode from the wrong place, or a code that names no mode.
              mode_next                = MODE_STANDBY;
              fault_next[FLT_MODE_BIT] = 1'b1;
            end
          end
        end
        FN_SYNC: begin
          d_rid   = {4'd0, node_addr};
          d_rsize = 4'd1;
          d_rlo   = {25'd0, node_addr};
        end
        FN_RSDO: begin
          if (fsize == 4'd0 || d_off_bad) begin
            fault_next[FLT_RX_BIT] = 1'b1;
          end else if (d_ccs == CCS_WRITE) begin
            d_sdo_wr = 1'b1;
          end else if (d_ccs == CCS_READ) begin
            d_sdo_rd = 1'b1;
            d_rid    = {FN_TSDO, node_addr};
            d_rsize  = 4'd4;
          end else begin
            fault_next[FLT_RX_BIT] = 1'b1;
          end
        end
        FN_RPDO1: begin
          d_rid   = {FN_TPDO1, node_addr};
          d_rsize = 4'd8;
          d_rlo   = dlo;
          d_rhi   = dhi;
          d_kick  = 1'b1;
        end
        FN_RPDO2: begin
          d_rid   = {FN_TPDO2, node_addr};
          d_rsize = 4'd8;
          d_rlo   = pos;
          d_rhi   = vel;
          d_kind  = KIND_PV;
          d_t1    = dlo;
          d_t2    = dhi;
          d_kick  = 1'b1;
        end
        FN_RPDO3: begin
          d_rid   = {FN_TPDO3, node_addr};
          d_rsize = 4'd8;
          d_rlo   = pos;
          d_rhi   = trq;
          d_kind  = KIND_PT;
          d_t1    = dlo;
          d_t2    = dhi;
          d_kick  = 1'b1;
        end
        FN_HEARTBEAT: begin
          d_kick = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(PARAM_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (d_sdo_wr) begin
          state_next = ST_WRITE;
        end else if (d_sdo_rd) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WRITE: begin
        if (byte_cnt == 2'd3) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        if (byte_cnt == 2'd3) begin
          state_next = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State machine outputs: input handshake, store port and result load.
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = off + ADDR_W'(byte_cnt);
    mem_wdata = dhi[8*byte_cnt +: 8];
    load_out  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 8'd0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_WRITE: begin
        mem_we = 1'b1;
      end
      ST_DONE: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      node_addr <= NODE_ID_RESET;
      mode      <= MODE_OFF;
      fault     <= '0;
      drive     <= 1'b0;
      byte_cnt  <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        node_addr <= node_id;
      end
      if (state == ST_DECODE) begin
        mode     <= mode_next;
        fault    <= fault_next;
        drive    <= drive_next;
        byte_cnt <= '0;
      end else if (state == ST_WRITE || state == ST_READ) begin
        byte_cnt <= byte_cnt + 2'd1;
      end
      rd_vld <= (state == ST_READ);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      fid   <= frame_id;
      fsize <= frame_size;
      dlo   <= data_lo;
      dhi   <= data_hi;
      pos   <= position_now;
      vel   <= velocity_now;
      trq   <= torque_now;
    end
    rd_idx <= byte_cnt;
    if (state == ST_DECODE) begin
      off       <= d_off[ADDR_W-1:0];
      res_id    <= d_rid;
      res_size  <= d_rsize;
      res_lo    <= d_rlo;
      res_hi    <= d_rhi;
      res_loops <= d_loops;
      res_kick  <= d_kick;
      res_kind  <= d_kind;
      res_t1    <= d_t1;
      res_t2    <= d_t2;
    end else if (rd_vld) begin
      res_lo[8*rd_idx +: 8] <= mem_rdata;
    end
    if (load_out) begin
      reply_id      <= res_id;
      reply_size    <= res_size;
      reply_lo      <= res_lo;
      reply_hi      <= res_hi;
      mode_now      <= mode;
      fault_flags   <= fault;
      drive_enable  <= drive;
      loops_reset   <= res_loops;
      watchdog_kick <= res_kick;
      target_kind   <= res_kind;
      target_first  <= res_t1;
      target_second <= res_t2;
    end
  end

endmodule

[test/cnfh_checker.sv]
`timescale 1ns / 1ps

module cnfh_checker
  import cnfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  node_id,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [10:0] frame_id,
  input  logic [3:0]  frame_size,
  input  logic [31:0] data_lo,
  input  logic [31:0] data_hi,
  input  logic [31:0] position_now,
  input  logic [31:0] velocity_now,
  input  logic [31:0] torque_now,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [10:0] reply_id,
  input  logic [3:0]  reply_size,
  input  logic [31:0] reply_lo,
  input  logic [31:0] reply_hi,
  input  logic [3:0]  mode_now,
  input  logic [1:0]  fault_flags,
  input  logic        drive_enable,
  input  logic        loops_reset,
  input  logic        watchdog_kick,
  input  logic [1:0]  target_kind,
  input  logic [31:0] target_first,
  input  logic [31:0] target_second,

  output int          pending,
  output int          mismatches
);

  typedef struct packed {
    logic [10:0] rid;
    logic [3:0]  rsize;
    logic [31:0] rlo;
    logic [31:0] rhi;
    logic [3:0]  mode;
    logic [1:0]  faults;
    logic        drive;
    logic        loops;
    logic        kick;
    logic [1:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
  } frame_result_t;

  // Node state as the block should hold it.
  logic [6:0]  node_q;
  logic [3:0]  mode_q;
  logic [1:0]  fault_q;
  logic        drive_q;
  logic        loops_q;
  logic [7:0]  param_mem [0:PARAM_BYTES-1];

  frame_result_t replies_due [$];

  function automatic logic is_run(input logic [7:0] m);
    return (m >= {4'd0, MODE_RUN_LO}) && (m <= {4'd0, MODE_RUN_HI});
  endfunction

  function automatic void enter_mode(input logic [7:0] req);
    if (req == {4'd0, mode_q}) return;
    drive_q = 1'b0;
    if (req == {4'd0, MODE_OFF} || req == {4'd0, MODE_STANDBY} ||
        req == {4'd0, MODE_SERVICE}) begin
      mode_q = req[3:0];
    end else if (req == {4'd0, MODE_CALIB}) begin
      loops_q = 1'b1;
      drive_q = 1'b1;
      mode_q  = req[3:0];
    end else if (is_run(req) && (mode_q == MODE_STANDBY || is_run({4'd0, mode_q}))) begin
      loops_q = 1'b1;
      drive_q = 1'b1;
      mode_q  = req[3:0];
    end else begin
      // A run mode from a mode that cannot reach it, or an unknown code.
      mode_q = MODE_STANDBY;
      fault_q[FLT_MODE_BIT] = 1'b1;
    end
  endfunction

  function automatic frame_result_t frame_outcome(input logic [10:0] id,
                                                  input logic [3:0]  size,
                                                  input logic [31:0] lo, hi,
                                                  input logic [31:0] pos, vel, tq);
    frame_result_t r;
    logic [6:0]    addr;
    logic [3:0]    fn;
    logic [2:0]    ccs;
    int            base;
    r       = '0;
    addr    = id[6:0];
    fn      = id[10:7];
    ccs     = lo[7:5];
    base    = int'(lo[23:8]);
    loops_q = 1'b0;
    if (addr == 7'd0 || addr == node_q) begin
      case (fn)
        FN_NMT: begin
          if (size == 4'd0) fault_q[FLT_RX_BIT] = 1'b1;
          else if (lo[15:8] == {1'b0, node_q}) enter_mode(lo[7:0]);
        end
        FN_SYNC: begin
          r.rid   = {4'd0, node_q};
          r.rsize = 4'd1;
          r.rlo   = {25'd0, node_q};
        end
        FN_RSDO: begin
          if (size == 4'd0 || base + 4 > PARAM_BYTES) begin
            fault_q[FLT_RX_BIT] = 1'b1;
          end else if (ccs == CCS_WRITE) begin
            for (int k = 0; k < 4; k++) param_mem[base + k] = hi[8*k +: 8];
          end else if (ccs == CCS_READ) begin
            r.rid   = {FN_TSDO, node_q};
            r.rsize = 4'd4;
            r.rlo   = {param_mem[base + 3], param_mem[base + 2],
                       param_mem[base + 1], param_mem[base]};
          end else begin
            fault_q[FLT_RX_BIT] = 1'b1;
          end
        end
        FN_RPDO1: begin
          r.rid   = {FN_TPDO1, node_q};
          r.rsize = 4'd8;
          r.rlo   = lo;
          r.rhi   = hi;
          r.kick  = 1'b1;
        end
        FN_RPDO2: begin
          r.rid    = {FN_TPDO2, node_q};
          r.rsize  = 4'd8;
          r.kind   = KIND_PV;
          r.first  = lo;
          r.second = hi;
          r.rlo    = pos;
          r.rhi    = vel;
          r.kick   = 1'b1;
        end
        FN_RPDO3: begin
          r.rid    = {FN_TPDO3, node_q};
          r.rsize  = 4'd8;
          r.kind   = KIND_PT;
          r.first  = lo;
          r.second = hi;
          r.rlo    = pos;
          r.rhi    = tq;
          r.kick   = 1'b1;
        end
        FN_HEARTBEAT: r.kick = 1'b1;
        default: ;
      endcase
    end
    r.mode   = mode_q;
    r.faults = fault_q;
    r.drive  = drive_q;
    r.loops  = loops_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      node_q  = NODE_ID_RESET;
      mode_q  = MODE_OFF;
      fault_q = 2'b00;
      drive_q = 1'b0;
      loops_q = 1'b0;
      for (int i = 0; i < PARAM_BYTES; i++) param_mem[i] = 8'h00;
      replies_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) node_q = node_id;
      // Results are compared before new frames are queued, since a result
      // can never belong to a frame taken at the same edge.
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result beat arrived with no frame outstanding");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("reply_id", 32'(want.rid), 32'(reply_id));
          check_field("reply_size", 32'(want.rsize), 32'(reply_size));
          check_field("reply_lo", want.rlo, reply_lo);
          check_field("reply_hi", want.rhi, reply_hi);
          check_field("mode_now", 32'(want.mode), 32'(mode_now));
          check_field("fault_flags", 32'(want.faults), 32'(fault_flags));
          check_field("drive_enable", 32'(want.drive), 32'(drive_enable));
          check_field("loops_reset", 32'(want.loops), 32'(loops_reset));
          check_field("watchdog_kick", 32'(want.kick), 32'(watchdog_kick));
          check_field("target_kind", 32'(want.kind), 32'(target_kind));
          check_field("target_first", want.first, target_first);
          check_field("target_second", want.second, target_second);
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(frame_outcome(frame_id, frame_size, data_lo, data_hi,
                                            position_now, velocity_now, torque_now));
    end
    pending <= replies_due.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Top of the frame handler bench. This module only makes stimulus and gives the
// verdict; the checker beside the block watches all three channels, predicts each
// result beat and compares it.

module testbench
  import cnfh_pkg::*;
();

  // Longest run of cycles with no beat on any channel before the run is declared
  // hung. It covers the post-reset store sweep and the longest stalls and gaps
  // with a wide margin.
  localparam int HANG_LIMIT = 4 * PARAM_BYTES;
  // Cycles to let pass after the last expected result before touching node_id
  // or ending the run.
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_FRAMES  = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_node = NODE_ID_RESET;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] frame_id = '0;
  logic [3:0]  frame_size = '0;
  logic [31:0] data_lo = '0;
  logic [31:0] data_hi = '0;
  logic [31:0] position_now = '0;
  logic [31:0] velocity_now = '0;
  logic [31:0] torque_now = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] reply_id;
  logic [3:0]  reply_size;
  logic [31:0] reply_lo;
  logic [31:0] reply_hi;
  logic [3:0]  mode_now;
  logic [1:0]  fault_flags;
  logic        drive_enable;
  logic        loops_reset;
  logic        watchdog_kick;
  logic [1:0]  target_kind;
  logic [31:0] target_first;
  logic [31:0] target_second;

  int          pending;
  int          mismatches;

  // The node id that the block currently holds, used to aim frames at it.
  logic [6:0]  node_now = NODE_ID_RESET;
  // While set, frames go back to back so that the block runs at full rate.
  logic        quiet = 1'b0;

  int          stall_left = 0;
  int          calm_left = 0;
  int          stuck_cycles = 0;

  always #1 clk = ~clk;

  can_node_frame_handler_top dut (.*, .node_id(cfg_node));

  cnfh_checker chk (.*, .node_id(cfg_node));

  // The result side stalls in bursts: mostly none or short ones, now and then a
  // long one, and from time to time a calm stretch with no stalls at all.
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      out_stall <= 1'b0;
      if (r < 2) calm_left <= $urandom_range(40, 200);
      else if (r < 20) stall_left <= $urandom_range(1, 3);
      else if (r < 24) stall_left <= $urandom_range(4, 40);
    end
  end

  // Hang detection: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Idle cycles to insert ahead of the next frame: usually none or a few,
  // occasionally a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Presents one frame beat and holds it until the block takes it. The valid
  // is left high so that a following frame can go out in the very next cycle.
  task automatic send_meas(input logic [10:0] id, input logic [3:0] size,
                           input logic [31:0] lo, hi, pos, vel, tq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    frame_id     <= id;
    frame_size   <= size;
    data_lo      <= lo;
    data_hi      <= hi;
    position_now <= pos;
    velocity_now <= vel;
    torque_now   <= tq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send(input logic [10:0] id, input logic [3:0] size,
                      input logic [31:0] lo, hi);
    send_meas(id, size, lo, hi, $urandom(), $urandom(), $urandom());
  endtask

  // NMT payload: byte 0 is the requested mode, byte 1 the addressed node. The
  // upper bytes carry noise, since the block must ignore them.
  function automatic logic [31:0] nmt_word(input logic [7:0] req, input logic [7:0] target);
    logic [31:0] w;
    w = $urandom();
    w[15:0] = {target, req};
    return w;
  endfunction

  // SDO payload: command specifier in byte 0 bits 7..5, offset in bytes 1..2.
  function automatic logic [31:0] sdo_word(input logic [2:0] ccs, input logic [15:0] off);
    logic [31:0] w;
    w = $urandom();
    w[23:5] = {off, ccs};
    return w;
  endfunction

  // Lets every outstanding result arrive, then a few more cycles, so that the
  // block is idle before node_id is changed or the verdict is given. The first
  // edge is waited out so that the pending count already covers the last frame.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node(input logic [6:0] value);
    cfg_node  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_now = value;
  endtask

  // Random frame: most are well formed and aimed at this node or broadcast, so
  // that mode changes, store traffic and PDO exchanges happen often; the rest is
  // noise on the whole id and payload.
  task automatic random_frame();
    logic [6:0]  addr;
    logic [3:0]  fn;
    logic [3:0]  size;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  req;
    logic [7:0]  target;
    logic [2:0]  ccs;
    logic [15:0] off;
    int          pick;
    int          r;
    pick = $urandom_range(0, 99);
    lo   = $urandom();
    hi   = $urandom();
    size = 4'($urandom_range(1, 8));
    if (pick < 12) begin
      send(11'($urandom_range(0, 2047)), 4'($urandom_range(0, 8)), lo, hi);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 5) addr = node_now;
      else if (r < 8) addr = 7'd0;
      else addr = 7'($urandom_range(0, 127));

      r = $urandom_range(0, 99);
      if (r < 30) fn = FN_NMT;
      else if (r < 55) fn = FN_RSDO;
      else if (r < 63) fn = FN_SYNC;
      else if (r < 73) fn = FN_RPDO1;
      else if (r < 82) fn = FN_RPDO2;
      else if (r < 91) fn = FN_RPDO3;
      else fn = FN_HEARTBEAT;

      if (fn == FN_NMT) begin
        // Favor idle and run modes so that the run-to-run transitions are
        // exercised, not only the refusal from disabled.
        r = $urandom_range(0, 99);
        if (r < 25) req = {4'd0, MODE_STANDBY};
        else if (r < 65) req = 8'($urandom_range(MODE_RUN_LO, MODE_RUN_HI));
        else if (r < 88) req = 8'($urandom_range(MODE_OFF, MODE_SERVICE));
        else req = 8'($urandom_range(0, 255));
        target = ($urandom_range(0, 9) != 0) ? {1'b0, node_now} : 8'($urandom_range(0, 255));
        lo = nmt_word(req, target);
        if ($urandom_range(0, 29) == 0) size = 4'd0;
      end else if (fn == FN_RSDO) begin
        r = $urandom_range(0, 99);
        if (r < 45) ccs = CCS_WRITE;
        else if (r < 90) ccs = CCS_READ;
        else ccs = 3'($urandom_range(0, 7));
        // A handful of word offsets gets most of the traffic, so that reads
        // often return data that was written earlier in the run.
        r = $urandom_range(0, 99);
        if (r < 60) off = 16'(4 * $urandom_range(0, 7));
        else if (r < 85) off = 16'($urandom_range(0, PARAM_BYTES - 4));
        else off = 16'($urandom_range(0, 65535));
        lo = sdo_word(ccs, off);
        if ($urandom_range(0, 49) == 0) size = 4'd0;
      end
      send({fn, addr}, size, lo, hi);
    end
  endtask

  initial begin
    logic [6:0] phase_node [4];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames, with node_id at its reset value.
    send({FN_SYNC, 7'd0}, 4'd0, 32'h0, 32'h0);               // broadcast sync
    send({FN_SYNC, node_now}, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send({FN_RPDO1, node_now + 7'd1}, 4'd8, $urandom(), $urandom()); // other node
    send(11'h7FF, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // other node, all ones
    send({FN_NMT, 7'd0}, 4'd0, 32'h0, 32'h0);                // empty NMT
    send({FN_NMT, 7'd0}, 4'd2,
         nmt_word({4'd0, MODE_STANDBY}, {1'b0, node_now + 7'd1}), 32'h0);
    send({FN_NMT, 7'd0}, 4'd2, nmt_word({4'd0, MODE_OFF}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, 7'd0}, 4'd2, nmt_word({4'd0, MODE_RUN_LO}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, 7'd0}, 4'd2, nmt_word({4'd0, MODE_RUN_LO}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, node_now}, 4'd2, nmt_word({4'd0, MODE_RUN_HI}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, node_now}, 4'd2, nmt_word({4'd0, MODE_CALIB}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, node_now}, 4'd2, nmt_word({4'd0, MODE_RUN_LO}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, node_now}, 4'd2, nmt_word({4'd0, MODE_SERVICE}, {1'b0, node_now}), 32'h0);
    send({FN_NMT, node_now}, 4'd2, nmt_word(8'hFF, {1'b0, node_now}), 32'h0);
    send({FN_NMT, node_now}, 4'd2, nmt_word({4'd0, MODE_OFF}, {1'b0, node_now}), 32'h0);
    send({FN_RSDO, node_now}, 4'd0, sdo_word(CCS_READ, 16'd0), 32'h0);   // empty SDO
    send({FN_RSDO, node_now}, 4'd8, sdo_word(CCS_WRITE, 16'd0), 32'hFFFF_FFFF);
    send({FN_RSDO, node_now}, 4'd8, sdo_word(CCS_READ, 16'd0), 32'h0);
    send({FN_RSDO, 7'd0}, 4'd8, sdo_word(CCS_WRITE, 16'(PARAM_BYTES - 4)), $urandom());
    send({FN_RSDO, 7'd0}, 4'd8, sdo_word(CCS_READ, 16'(PARAM_BYTES - 4)), 32'h0);
    send({FN_RSDO, 7'd0}, 4'd8, sdo_word(CCS_READ, 16'(PARAM_BYTES - 3)), 32'h0);
    send({FN_RSDO, 7'd0}, 4'd8, sdo_word(CCS_WRITE, 16'hFFFF), $urandom());
    send({FN_RSDO, 7'd0}, 4'd8, sdo_word(3'd7, 16'd4), $urandom());      // bad specifier
    send({FN_RPDO1, node_now}, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_meas({FN_RPDO2, node_now}, 4'd8, $urandom(), $urandom(),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_meas({FN_RPDO3, 7'd0}, 4'd8, $urandom(), $urandom(), 32'h0, 32'h0, 32'h0);
    send({FN_HEARTBEAT, node_now}, 4'd0, 32'h0, 32'h0);
    send({FN_RPDO4, node_now}, 4'd8, $urandom(), $urandom());            // RPDO4 is ignored
    drain();

    // Random phases, each under a different node id, the extremes among them.
    phase_node[0] = 7'd127;
    phase_node[1] = 7'd0;
    phase_node[2] = 7'($urandom_range(2, 126));
    phase_node[3] = NODE_ID_RESET;
    for (int p = 0; p < 4; p++) begin
      write_node(phase_node[p]);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        quiet = ((n / 30) % 4 == 3);
        random_frame();
      end
      quiet = 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
